// ===== sv/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scan unit.
package wbps_pkg;

    // Word opcodes carried on the input mode field
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_START  = 2'd2,
        MODE_SCAN   = 2'd3
    } scan_mode_t;

    // Config register indexes (paddr[2])
    localparam logic REG_BASE_ADDR = 1'b0;

    localparam int unsigned  ADDR_W      = 32;
    localparam int unsigned  LEAD_W      = 16;
    localparam logic [15:0]  LEAD_MAX    = 16'hFFFF;

    // Broadcast control from the front end to every cell of the chain
    typedef struct packed {
        logic       clear_pat;  // drop whole pattern
        logic       clear_pm;   // drop partial-match bits only
        logic       scan;       // shift in one data byte
        logic       store;      // write entry at entry_count
        logic       literal;    // stored entry is a literal
        logic [7:0] pat_byte;
        logic [7:0] data_byte;
    } wbps_cell_ctrl_t;

endpackage

// ===== sv/wbps_cell.sv =====
// One pattern cell: entry value, care bit, tail mark and partial-match bit.
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int unsigned IDX_W = 9,
    parameter int unsigned INDEX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  wbps_cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0] entry_count,
    input  logic            prev_match,
    output logic            match_out,
    output logic            tail_hit,
    output logic            tail_out
);

    logic       sel;
    logic       loaded_reg;
    logic       care_reg;
    logic       tail_reg;
    logic       pm_reg;
    logic [7:0] value_reg;

    assign sel = (entry_count == IDX_W'(INDEX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= 1'b0;
            care_reg   <= 1'b0;
            tail_reg   <= 1'b0;
            pm_reg     <= 1'b0;
        end else if (ctrl.clear_pat) begin
            loaded_reg <= 1'b0;
            care_reg   <= 1'b0;
            tail_reg   <= 1'b0;
            pm_reg     <= 1'b0;
        end else begin
            if (ctrl.clear_pm) begin
                pm_reg <= 1'b0;
            end
            if (ctrl.store && sel) begin
                loaded_reg <= 1'b1;
                care_reg   <= ctrl.literal;
            end
            // last literal marks the end of the compared length
            if (ctrl.store && ctrl.literal) begin
                tail_reg <= sel;
            end
            if (ctrl.scan && loaded_reg) begin
                pm_reg <= prev_match && (!care_reg || (value_reg == ctrl.data_byte));
            end
        end
    end

    // entry value has no reset; only read once loaded
    always_ff @(posedge aclk) begin
        if (ctrl.store && sel) begin
            value_reg <= ctrl.literal ? ctrl.pat_byte : 8'd0;
        end
    end

    assign match_out = pm_reg;
    assign tail_hit  = pm_reg & tail_reg;
    assign tail_out  = tail_reg;

endmodule

// ===== sv/wildcard_byte_pattern_scan_unit.sv =====
// Top level of the wildcard byte pattern scan unit: front end, cell chain, result stage.
// Result path: accepted word -> pend stage -> registered output word (m_valid high after it).
// Throughput: one word per cycle while m_ready drains results; every cell of the chain compares
//   the scanned byte with its entry in the same cycle; tail OR and address add sit one stage later.
// Reset (aresetn low, synchronous): pattern, partial matches, counters, the base address
//   register and the output valid clear; stored entry bytes keep whatever they held.
module wildcard_byte_pattern_scan_unit
    import wbps_pkg::*;
#(
    parameter int unsigned PATTERN_DEPTH = 256,
    parameter int unsigned MAX_MATCHES   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_pattern_byte,
    input  logic        s_pattern_wildcard,
    input  logic [7:0]  s_data_byte,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_match_found,
    output logic [31:0] m_match_address,
    output logic [6:0]  m_match_count,
    output logic        m_results_full,
    output logic        m_pattern_overflow
);

    localparam int unsigned EC_W  = $clog2(PATTERN_DEPTH + 1);
    localparam int unsigned CNT_W = $clog2(MAX_MATCHES + 1);

    // ---------------- config register ----------------
    logic [ADDR_W-1:0] base_addr_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BASE_ADDR)) begin
            base_addr_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_BASE_ADDR) ? base_addr_reg : 32'd0;

    // ---------------- front end (stage 0) ----------------
    // Pattern bookkeeping updates on accept; cells update on the same edge.
    scan_mode_t        mode;
    logic              s_fire;
    logic              lead_wild;
    logic              store;
    logic              overflow;
    logic [EC_W-1:0]   entry_count_reg, entry_count_next;
    logic [EC_W-1:0]   cl_reg, cl_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic              seen_reg, seen_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;

    assign mode      = scan_mode_t'(s_mode);
    assign s_fire    = s_valid && s_ready;
    // wildcards ahead of the first literal are only counted
    assign lead_wild = s_pattern_wildcard && !seen_reg;
    assign store     = (mode == MODE_APPEND) && !lead_wild &&
                       (entry_count_reg < EC_W'(PATTERN_DEPTH));
    assign overflow  = (mode == MODE_APPEND) && !lead_wild &&
                       (entry_count_reg >= EC_W'(PATTERN_DEPTH));

    always_comb begin
        entry_count_next = entry_count_reg;
        cl_next          = cl_reg;
        lead_next        = lead_reg;
        seen_next        = seen_reg;
        if (mode == MODE_CLEAR) begin
            entry_count_next = '0;
            cl_next          = '0;
            lead_next        = '0;
            seen_next        = 1'b0;
        end else if (mode == MODE_APPEND) begin
            if (lead_wild) begin
                if (lead_reg != LEAD_MAX) begin
                    lead_next = lead_reg + 1'b1;
                end
            end else if (store) begin
                entry_count_next = entry_count_reg + 1'b1;
                if (!s_pattern_wildcard) begin
                    seen_next = 1'b1;
                    cl_next   = entry_count_reg + 1'b1;
                end
            end
        end
        // start = pos - (cl - 1); address subtracts that and the lead count together
        if (cl_next == '0) begin
            offset_next = ADDR_W'(lead_next);
        end else begin
            offset_next = ADDR_W'(cl_next) - 32'd1 + ADDR_W'(lead_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            cl_reg          <= '0;
            lead_reg        <= '0;
            seen_reg        <= 1'b0;
            offset_reg      <= '0;
        end else if (s_fire) begin
            entry_count_reg <= entry_count_next;
            cl_reg          <= cl_next;
            lead_reg        <= lead_next;
            seen_reg        <= seen_next;
            offset_reg      <= offset_next;
        end
    end

    // ---------------- cell chain ----------------
    wbps_cell_ctrl_t        ctrl;
    logic [PATTERN_DEPTH-1:0] pm_vec;
    logic [PATTERN_DEPTH-1:0] hit_vec;
    logic [PATTERN_DEPTH-1:0] tail_vec;

    always_comb begin
        ctrl.clear_pat = s_fire && (mode == MODE_CLEAR);
        ctrl.clear_pm  = s_fire && ((mode == MODE_APPEND) || (mode == MODE_START));
        ctrl.scan      = s_fire && (mode == MODE_SCAN);
        ctrl.store     = s_fire && store;
        ctrl.literal   = !s_pattern_wildcard;
        ctrl.pat_byte  = s_pattern_byte;
        ctrl.data_byte = s_data_byte;
    end

    for (genvar g = 0; g < PATTERN_DEPTH; g++) begin : g_cell
        logic prev;
        if (g == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = pm_vec[g-1];
        end
        wbps_cell #(
            .IDX_W (EC_W),
            .INDEX (g)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .entry_count (entry_count_reg),
            .prev_match  (prev),
            .match_out   (pm_vec[g]),
            .tail_hit    (hit_vec[g]),
            .tail_out    (tail_vec[g])
        );
    end

    // ---------------- result stage (stage 1) ----------------
    logic              pend_reg;
    scan_mode_t        pend_mode_reg;
    logic              pend_ovf_reg;
    logic              fin;
    logic [ADDR_W-1:0] pos_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W+6:0]  cnt_wide;
    logic              hit;
    logic              found;
    logic [ADDR_W-1:0] addr;

    logic              m_valid_reg;
    logic              m_found_reg;
    logic [31:0]       m_addr_reg;
    logic [6:0]        m_count_reg;
    logic              m_full_reg;
    logic              m_ovf_reg;

    // result stage advances when the output word is free or being taken
    assign fin     = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready = !pend_reg || fin;

    // empty compared length matches at every byte
    assign hit   = (cl_reg == '0) || (|hit_vec);
    assign found = (pend_mode_reg == MODE_SCAN) && hit && (cnt_reg < CNT_W'(MAX_MATCHES));
    assign addr  = found ? (base_addr_reg + pos_reg - offset_reg) : 32'd0;

    always_comb begin
        cnt_next = cnt_reg;
        if (pend_mode_reg == MODE_START) begin
            cnt_next = '0;
        end else if (found) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign cnt_wide = {7'd0, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            pend_mode_reg <= MODE_CLEAR;
            pend_ovf_reg  <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_fire) begin
                pend_reg      <= 1'b1;
                pend_mode_reg <= mode;
                pend_ovf_reg  <= overflow;
            end else if (fin) begin
                pend_reg <= 1'b0;
            end
            if (fin) begin
                cnt_reg <= cnt_next;
                if (pend_mode_reg == MODE_START) begin
                    pos_reg <= '0;
                end else if (pend_mode_reg == MODE_SCAN) begin
                    pos_reg <= pos_reg + 32'd1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if (fin) begin
            m_found_reg <= found;
            m_addr_reg  <= addr;
            m_count_reg <= cnt_wide[6:0];
            m_full_reg  <= (cnt_next >= CNT_W'(MAX_MATCHES));
            m_ovf_reg   <= pend_ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_match_found      = m_found_reg;
    assign m_match_address    = m_addr_reg;
    assign m_match_count      = m_count_reg;
    assign m_results_full     = m_full_reg;
    assign m_pattern_overflow = m_ovf_reg;

    // ---------------- assertions ----------------
    a_tail_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tail_vec))
        else $error("more than one cell marked as pattern tail");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_MATCHES))
        else $error("match counter ran past its limit");

    a_found_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_found |-> m_match_count != 7'd0)
        else $error("match reported with zero count");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_mode == MODE_CLEAR) |=> (entry_count_reg == '0) && (tail_vec == '0))
        else $error("pattern clear left entries behind");

endmodule
